@@ src/ccra_pkg.sv @@
// ----------------------------------------------------------------------------
// ccra_pkg
// Shared types and codes of the calendar clock: beat payloads, action codes,
// configuration register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ccra_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_LOAD     = 2'd1;
    localparam logic [1:0] ACT_SET_TIME = 2'd2;
    localparam logic [1:0] ACT_SET_DATE = 2'd3;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAUSED = 8'd1;

    // input beat
    typedef struct packed {
        logic [1:0]  action;
        logic [23:0] elapsed_time;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [16:0] minutes_advanced;
        logic        accepted;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [2:0]  weekday;
        logic [2:0]  day_period;
    } out_item_t;

    // step commands from the controller
    typedef struct packed {
        logic capture;
        logic execute;
        logic accumulate;
        logic div_minutes;
        logic fold_minutes;
        logic div_hours;
        logic fold_hours;
        logic month_step;
        logic wday_div;
        logic wday_sum;
        logic load_out;
    } ccra_cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic run_tick;
        logic carry_needed;
        logic month_over;
    } ccra_status_t;

endpackage

@@ src/ccra_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccra_ctrl
// Sequencer of the calendar clock: walks one item through accumulation,
// minute/hour/day carries, month stepping, weekday and result hand-off.
// ----------------------------------------------------------------------------
module ccra_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  ccra_pkg::ccra_status_t status,
    output ccra_pkg::ccra_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADD,
        ST_DIV60,
        ST_HRS,
        ST_DIV24,
        ST_DAYS,
        ST_MONTH,
        ST_WK1,
        ST_WK2,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // next state and step commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = status.run_tick ? ST_ADD : ST_WK1;
            end
            ST_ADD: begin
                cmd.accumulate = 1'b1;
                state_next     = status.carry_needed ? ST_DIV60 : ST_WK1;
            end
            ST_DIV60: begin
                cmd.div_minutes = 1'b1;
                state_next      = ST_HRS;
            end
            ST_HRS: begin
                cmd.fold_minutes = 1'b1;
                state_next       = ST_DIV24;
            end
            ST_DIV24: begin
                cmd.div_hours = 1'b1;
                state_next    = ST_DAYS;
            end
            ST_DAYS: begin
                cmd.fold_hours = 1'b1;
                state_next     = ST_MONTH;
            end
            ST_MONTH: begin
                cmd.month_step = 1'b1;
                state_next     = status.month_over ? ST_MONTH : ST_WK1;
            end
            ST_WK1: begin
                cmd.wday_div = 1'b1;
                state_next   = ST_WK2;
            end
            ST_WK2: begin
                cmd.wday_sum = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                // output register free or being emptied this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/ccra_datapath.sv @@
// ----------------------------------------------------------------------------
// ccra_datapath
// Clock and calendar registers, rate accumulator, constant-reciprocal
// dividers for the minute and hour carries, month stepper, weekday and
// day-period logic, configuration registers and the result register.
// ----------------------------------------------------------------------------
module ccra_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ccra_pkg::ccra_cmd_t                 cmd,
    output ccra_pkg::ccra_status_t              status,
    input  ccra_pkg::in_item_t                  s_data,
    output ccra_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    input  logic [ccra_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ccra_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [15:0] RATE_RESET = 16'd256;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_BIAS  = 14'd400;
    // ceil(2^21/60), exact for values below 74898
    localparam logic [33:0] RECIP60    = 34'd34953;
    // ceil(2^9/3), exact for values below 512
    localparam logic [15:0] RECIP3     = 16'd171;
    // ceil(2^20/100), exact for values below 43690
    localparam logic [27:0] RECIP100   = 28'd10486;
    // inverse of 25 modulo 2^12 and the divisibility bound
    localparam logic [23:0] INV25      = 24'd3113;
    localparam logic [11:0] LIM25      = 12'd163;

    // minute-of-day bounds of the day periods
    localparam logic [10:0] TOD_MORNING   = 11'd300;
    localparam logic [10:0] TOD_FORENOON  = 11'd420;
    localparam logic [10:0] TOD_NOON      = 11'd660;
    localparam logic [10:0] TOD_AFTERNOON = 11'd780;
    localparam logic [10:0] TOD_EARLY_EVE = 11'd1020;
    localparam logic [10:0] TOD_EVENING   = 11'd1140;
    localparam logic [10:0] TOD_NIGHT     = 11'd1260;

    localparam logic [2:0] PER_MORNING   = 3'd0;
    localparam logic [2:0] PER_FORENOON  = 3'd1;
    localparam logic [2:0] PER_NOON      = 3'd2;
    localparam logic [2:0] PER_AFTERNOON = 3'd3;
    localparam logic [2:0] PER_EARLY_EVE = 3'd4;
    localparam logic [2:0] PER_EVENING   = 3'd5;
    localparam logic [2:0] PER_NIGHT     = 3'd6;

    // gregorian leap rule; divisibility by 100 checked as (y/4) divisible by 25
    function automatic logic is_leap(input logic [13:0] y);
        logic [23:0] p;
        logic        div25;
        p     = 24'(y[13:2]) * INV25;
        div25 = (p[11:0] <= LIM25);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
    endfunction

    // days in a month; months outside 1..12 count as 30 days
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    // zeller month term 13*(m+1)/5, with january and february as 13 and 14
    function automatic logic [5:0] zeller_term(input logic [3:0] m);
        logic [5:0] t;
        unique case (m)
            4'd0:    t = 6'd33;
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd41;
        endcase
        return t;
    endfunction

    // x mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [9:0] x);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
        f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
        return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    endfunction

    // configuration and clock state
    logic [15:0] rate_reg;
    logic        paused_reg;
    logic [5:0]  minute_reg;
    logic [4:0]  hour_reg;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [13:0] year_reg;
    logic [23:0] frac_reg;

    // per-item work registers
    ccra_pkg::in_item_t  item_reg;
    ccra_pkg::out_item_t out_reg;
    logic [39:0] prod_reg;
    logic [16:0] adv_reg;
    logic        acc_reg;
    logic [16:0] mins_reg;
    logic [10:0] q60_reg;
    logic [10:0] hours_reg;
    logic [5:0]  q24_reg;
    logic [6:0]  day_work_reg;
    logic [13:0] wk_y_reg;
    logic [6:0]  wk_j_reg;
    logic [9:0]  wk_s_reg;

    logic [40:0] sum;
    logic [16:0] mins_sum;
    logic [33:0] q60_prod;
    logic [16:0] min_fold;
    logic [10:0] hours_sum;
    logic [15:0] q24_prod;
    logic [10:0] hour_fold;
    logic [6:0]  day_sum;
    logic [4:0]  cur_len;
    logic        time_ok;
    logic        date_ok;
    logic [13:0] year_sat;
    logic        m_early;
    logic [13:0] wk_y;
    logic [27:0] j_prod;
    logic [13:0] k_full;
    logic [6:0]  k_val;
    logic [9:0]  wk_s;
    logic [2:0]  zel_h;
    logic [2:0]  wday;
    logic [10:0] tod;
    logic [2:0]  period;

    // accumulator and carry arithmetic
    always_comb begin
        sum       = {1'b0, prod_reg} + 41'(frac_reg);
        mins_sum  = 17'(minute_reg) + sum[40:24];
        q60_prod  = 34'(mins_reg) * RECIP60;
        min_fold  = mins_reg - 17'(q60_reg) * 17'd60;
        hours_sum = 11'(hour_reg) + q60_reg;
        q24_prod  = 16'(hours_reg[10:3]) * RECIP3;
        hour_fold = hours_reg - 11'(q24_reg) * 11'd24;
        day_sum   = 7'(day_reg) + 7'(q24_reg);
        cur_len   = month_len(month_reg, year_reg);
    end

    // set validation
    always_comb begin
        time_ok  = (item_reg.new_hour <= 5'd23) && (item_reg.new_minute <= 6'd59);
        date_ok  = (item_reg.new_year >= 14'd1) && (item_reg.new_year <= YEAR_MAX)
                && (item_reg.new_month >= 4'd1) && (item_reg.new_month <= 4'd12)
                && (item_reg.new_day >= 5'd1)
                && (item_reg.new_day <= month_len(item_reg.new_month, item_reg.new_year));
        year_sat = (item_reg.new_year > YEAR_MAX) ? YEAR_MAX : item_reg.new_year;
    end

    // weekday by zeller and the day period
    always_comb begin
        m_early = (month_reg < 4'd3);
        wk_y    = year_reg + YEAR_BIAS - 14'(m_early);
        j_prod  = 28'(wk_y) * RECIP100;
        k_full  = wk_y_reg - 14'(wk_j_reg) * 14'd100;
        k_val   = k_full[6:0];
        wk_s    = 10'(day_reg) + 10'(zeller_term(month_reg)) + 10'(k_val)
                + 10'(k_val[6:2]) + 10'(wk_j_reg[6:2]) + 10'(wk_j_reg) * 10'd5;
        zel_h   = mod7(wk_s_reg);
        wday    = (zel_h >= 3'd2) ? zel_h - 3'd2 : zel_h + 3'd5;
        tod     = 11'(hour_reg) * 11'd60 + 11'(minute_reg);
        priority if (tod >= TOD_MORNING && tod < TOD_FORENOON) begin
            period = PER_MORNING;
        end else if (tod >= TOD_FORENOON && tod < TOD_NOON) begin
            period = PER_FORENOON;
        end else if (tod >= TOD_NOON && tod < TOD_AFTERNOON) begin
            period = PER_NOON;
        end else if (tod >= TOD_AFTERNOON && tod < TOD_EARLY_EVE) begin
            period = PER_AFTERNOON;
        end else if (tod >= TOD_EARLY_EVE && tod < TOD_EVENING) begin
            period = PER_EARLY_EVE;
        end else if (tod >= TOD_EVENING && tod < TOD_NIGHT) begin
            period = PER_EVENING;
        end else begin
            period = PER_NIGHT;
        end
    end

    // status to the controller
    assign status.run_tick     = (item_reg.action == ccra_pkg::ACT_TICK) && !paused_reg;
    assign status.carry_needed = (sum[40:24] != 17'd0);
    assign status.month_over   = (day_work_reg > 7'(cur_len));

    assign m_data = out_reg;

    // configuration and clock state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= RATE_RESET;
            paused_reg <= 1'b0;
            minute_reg <= 6'd0;
            hour_reg   <= 5'd0;
            day_reg    <= 5'd1;
            month_reg  <= 4'd1;
            year_reg   <= 14'd1;
            frac_reg   <= 24'd0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == ccra_pkg::CFG_RATE) begin
                    rate_reg <= cfg_data;
                end else if (cfg_index == ccra_pkg::CFG_PAUSED) begin
                    paused_reg <= cfg_data[0];
                end
            end
            if (cmd.execute) begin
                unique case (item_reg.action)
                    ccra_pkg::ACT_TICK: begin
                    end
                    ccra_pkg::ACT_LOAD: begin
                        day_reg    <= item_reg.new_day;
                        month_reg  <= item_reg.new_month;
                        year_reg   <= year_sat;
                        hour_reg   <= item_reg.new_hour;
                        minute_reg <= item_reg.new_minute;
                        frac_reg   <= 24'd0;
                    end
                    ccra_pkg::ACT_SET_TIME: begin
                        if (time_ok) begin
                            hour_reg   <= item_reg.new_hour;
                            minute_reg <= item_reg.new_minute;
                        end
                    end
                    ccra_pkg::ACT_SET_DATE: begin
                        if (date_ok) begin
                            day_reg   <= item_reg.new_day;
                            month_reg <= item_reg.new_month;
                            year_reg  <= item_reg.new_year;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (cmd.accumulate) begin
                frac_reg <= sum[23:0];
            end else if (cmd.fold_minutes) begin
                minute_reg <= min_fold[5:0];
            end else if (cmd.fold_hours) begin
                hour_reg <= hour_fold[4:0];
            end else if (cmd.month_step) begin
                if (status.month_over) begin
                    // roll into the next month, year holds at its limit
                    if (month_reg >= 4'd12) begin
                        month_reg <= 4'd1;
                        if (year_reg < YEAR_MAX) begin
                            year_reg <= year_reg + 14'd1;
                        end
                    end else begin
                        month_reg <= month_reg + 4'd1;
                    end
                end else begin
                    day_reg <= day_work_reg[4:0];
                end
            end
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
            adv_reg  <= 17'd0;
        end
        if (cmd.execute) begin
            prod_reg <= 40'(item_reg.elapsed_time) * 40'(rate_reg);
            unique case (item_reg.action)
                ccra_pkg::ACT_TICK:     acc_reg <= 1'b1;
                ccra_pkg::ACT_LOAD:     acc_reg <= 1'b1;
                ccra_pkg::ACT_SET_TIME: acc_reg <= time_ok;
                ccra_pkg::ACT_SET_DATE: acc_reg <= date_ok;
                default:                acc_reg <= 1'b0;
            endcase
        end
        if (cmd.accumulate) begin
            adv_reg  <= sum[40:24];
            mins_reg <= mins_sum;
        end
        if (cmd.div_minutes) begin
            q60_reg <= q60_prod[31:21];
        end
        if (cmd.fold_minutes) begin
            hours_reg <= hours_sum;
        end
        if (cmd.div_hours) begin
            q24_reg <= q24_prod[14:9];
        end
        if (cmd.fold_hours) begin
            day_work_reg <= day_sum;
        end
        if (cmd.month_step && status.month_over) begin
            day_work_reg <= day_work_reg - 7'(cur_len);
        end
        if (cmd.wday_div) begin
            wk_y_reg <= wk_y;
            wk_j_reg <= j_prod[26:20];
        end
        if (cmd.wday_sum) begin
            wk_s_reg <= wk_s;
        end
        if (cmd.load_out) begin
            out_reg.minutes_advanced <= adv_reg;
            out_reg.accepted         <= acc_reg;
            out_reg.cur_day          <= day_reg;
            out_reg.cur_month        <= month_reg;
            out_reg.cur_year         <= year_reg;
            out_reg.cur_hour         <= hour_reg;
            out_reg.cur_minute       <= minute_reg;
            out_reg.weekday          <= wday;
            out_reg.day_period       <= period;
        end
    end

endmodule

@@ src/calendar_clock_with_rate_accumulator_top.sv @@
// A set, load or paused tick item runs execute, the weekday steps and the output load; a running
// tick adds accumulation, and a minute carry adds the carry division, folds and month stepping.
// A new item is taken only in idle, after the previous item's result has been loaded.
// The result register lets the next item enter while a result waits on m_ready.
// Reset (aresetn low, synchronous): 00:00 on day 1, month 1, year 1, fraction 0,
// rate 1.0 minute per second, not paused, no result pending.
// ----------------------------------------------------------------------------
// calendar_clock_with_rate_accumulator_top
// Gregorian calendar clock advanced by real elapsed time times a Q8.8 rate,
// with date/time set commands, weekday and day-period reporting.
// ----------------------------------------------------------------------------
module calendar_clock_with_rate_accumulator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ccra_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ccra_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccra_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ccra_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ccra_pkg::ccra_cmd_t    cmd;
    ccra_pkg::ccra_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    ccra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // clock, calendar and arithmetic
    ccra_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
